[hdl/pglcp_pkg.sv]
// shared constants, types and helper functions of the lock command parser
`timescale 1ns / 1ps

package pglcp_pkg;

  localparam int PIN_LENGTH = 4;
  localparam int BYTE_W     = 8;
  // byte counter covers a whole frame of pin bytes plus command byte
  localparam int CNT_W      = $clog2(PIN_LENGTH + 1);

  localparam int OK_LEN      = 3;
  localparam int ERR_LEN     = 4;
  localparam int REPLY_IDX_W = $clog2(ERR_LEN);

  typedef logic [BYTE_W-1:0] char_t;
  typedef char_t [PIN_LENGTH-1:0] pin_t;

  localparam char_t CMD_UNLOCK_UC = 8'h55;  // U
  localparam char_t CMD_UNLOCK_LC = 8'h75;  // u
  localparam char_t CMD_LOCK_UC   = 8'h4c;  // L
  localparam char_t CMD_LOCK_LC   = 8'h6c;  // l
  localparam char_t CMD_CHANGE_UC = 8'h43;  // C
  localparam char_t CMD_CHANGE_LC = 8'h63;  // c
  localparam char_t CHAR_0        = 8'h30;
  localparam char_t CHAR_1        = 8'h31;
  localparam char_t CHAR_9        = 8'h39;
  localparam char_t CHAR_O        = 8'h4f;
  localparam char_t CHAR_K        = 8'h4b;
  localparam char_t CHAR_E        = 8'h45;
  localparam char_t CHAR_R        = 8'h52;
  localparam char_t CHAR_NL       = 8'h0a;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_OK,
    REPLY_ERR
  } reply_kind_t;

  typedef struct packed {
    reply_kind_t kind;
    logic        relay;
  } reply_req_t;

  function automatic char_t reply_char(input reply_kind_t kind,
                                       input logic [REPLY_IDX_W-1:0] idx);
    char_t c;
    c = CHAR_NL;
    case (kind)
      REPLY_OK: begin
        case (idx)
          REPLY_IDX_W'(0): c = CHAR_O;
          REPLY_IDX_W'(1): c = CHAR_K;
          default:         c = CHAR_NL;
        endcase
      end
      REPLY_ERR: begin
        case (idx)
          REPLY_IDX_W'(0): c = CHAR_E;
          REPLY_IDX_W'(1): c = CHAR_R;
          REPLY_IDX_W'(2): c = CHAR_R;
          default:         c = CHAR_NL;
        endcase
      end
      default: c = CHAR_NL;
    endcase
    return c;
  endfunction

  function automatic logic [REPLY_IDX_W-1:0] reply_last_idx(input reply_kind_t kind);
    logic [REPLY_IDX_W-1:0] idx;
    case (kind)
      REPLY_OK: idx = REPLY_IDX_W'(OK_LEN - 1);
      default:  idx = REPLY_IDX_W'(ERR_LEN - 1);
    endcase
    return idx;
  endfunction

endpackage

[hdl/pglcp_if.sv]
// valid/ready channel interfaces for received bytes and reply bytes
`timescale 1ns / 1ps

interface pglcp_in_if;
  logic                  valid;
  logic                  ready;
  pglcp_pkg::char_t      rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pglcp_out_if;
  logic                  valid;
  logic                  ready;
  pglcp_pkg::char_t      reply_byte;
  logic                  reply_last;
  logic                  relay_unlock;

  modport source (output valid, output reply_byte, output reply_last,
                  output relay_unlock, input ready);
  modport sink   (input valid, input reply_byte, input reply_last,
                  input relay_unlock, output ready);
endinterface

[hdl/pglcp_parser.sv]
// input register, frame and pin state, and command decision
`timescale 1ns / 1ps

module pglcp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  pglcp_in_if.sink              in_ch,
  output pglcp_pkg::reply_req_t req,
  input  logic                  req_ready
);

  logic                          hold_valid_r, hold_valid_nxt;
  pglcp_pkg::char_t              hold_byte_r;
  logic [pglcp_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                          new_phase_r, new_phase_nxt;
  logic                          old_match_r, old_match_nxt;
  logic                          relay_r, relay_nxt;
  pglcp_pkg::pin_t               stored_pin_r, stored_pin_nxt;
  pglcp_pkg::pin_t               frame_pin_r, frame_pin_nxt;
  pglcp_pkg::pin_t               pending_pin_r, pending_pin_nxt;

  logic                          frame_last;
  logic                          pin_last;
  logic                          match;
  logic                          digits;
  logic                          fire;
  pglcp_pkg::char_t              cand;
  pglcp_pkg::reply_req_t         req_c;

  assign frame_last = hold_valid_r && !new_phase_r &&
                      (count_r == pglcp_pkg::CNT_W'(pglcp_pkg::PIN_LENGTH));
  assign pin_last   = hold_valid_r && new_phase_r &&
                      (count_r == pglcp_pkg::CNT_W'(pglcp_pkg::PIN_LENGTH - 1));

  always_comb begin
    match  = 1'b1;
    digits = 1'b1;
    cand   = hold_byte_r;
    for (int i = 0; i < pglcp_pkg::PIN_LENGTH; i++) begin
      if (frame_pin_r[i] != stored_pin_r[i]) match = 1'b0;
      // the final new-pin byte is still in the input register
      cand = (i == pglcp_pkg::PIN_LENGTH - 1) ? hold_byte_r : pending_pin_r[i];
      if (!(cand inside {[pglcp_pkg::CHAR_0:pglcp_pkg::CHAR_9]})) digits = 1'b0;
    end
  end

  always_comb begin
    req_c.kind  = pglcp_pkg::REPLY_NONE;
    req_c.relay = relay_r;
    if (pin_last) begin
      req_c.kind = (old_match_r && digits) ? pglcp_pkg::REPLY_OK : pglcp_pkg::REPLY_ERR;
    end else if (frame_last) begin
      if (hold_byte_r inside {pglcp_pkg::CMD_CHANGE_UC, pglcp_pkg::CMD_CHANGE_LC}) begin
        req_c.kind = pglcp_pkg::REPLY_NONE;
      end else if (!match) begin
        req_c.kind = pglcp_pkg::REPLY_ERR;
      end else if (hold_byte_r inside {pglcp_pkg::CMD_UNLOCK_UC, pglcp_pkg::CMD_UNLOCK_LC}) begin
        req_c.kind  = pglcp_pkg::REPLY_OK;
        req_c.relay = 1'b1;
      end else if (hold_byte_r inside {pglcp_pkg::CMD_LOCK_UC, pglcp_pkg::CMD_LOCK_LC}) begin
        req_c.kind  = pglcp_pkg::REPLY_OK;
        req_c.relay = 1'b0;
      end else begin
        req_c.kind = pglcp_pkg::REPLY_ERR;
      end
    end
  end

  // a reply-producing byte waits until the serializer can take the reply
  assign fire = hold_valid_r && ((req_c.kind == pglcp_pkg::REPLY_NONE) || req_ready);

  assign req.kind  = fire ? req_c.kind : pglcp_pkg::REPLY_NONE;
  assign req.relay = req_c.relay;

  assign in_ch.ready = !hold_valid_r || fire;

  always_comb begin
    hold_valid_nxt  = in_ch.valid ? 1'b1 : (hold_valid_r && !fire);
    count_nxt       = count_r;
    new_phase_nxt   = new_phase_r;
    old_match_nxt   = old_match_r;
    relay_nxt       = relay_r;
    stored_pin_nxt  = stored_pin_r;
    frame_pin_nxt   = frame_pin_r;
    pending_pin_nxt = pending_pin_r;
    if (fire) begin
      relay_nxt = req_c.relay;
      for (int i = 0; i < pglcp_pkg::PIN_LENGTH; i++) begin
        if (count_r == pglcp_pkg::CNT_W'(i)) begin
          if (new_phase_r) pending_pin_nxt[i] = hold_byte_r;
          else             frame_pin_nxt[i]   = hold_byte_r;
        end
      end
      if (pin_last) begin
        count_nxt     = '0;
        new_phase_nxt = 1'b0;
        if (req_c.kind == pglcp_pkg::REPLY_OK) begin
          stored_pin_nxt = pending_pin_nxt;
        end
      end else if (frame_last) begin
        count_nxt = '0;
        if (hold_byte_r inside {pglcp_pkg::CMD_CHANGE_UC, pglcp_pkg::CMD_CHANGE_LC}) begin
          new_phase_nxt = 1'b1;
          old_match_nxt = match;
        end
      end else begin
        count_nxt = count_r + pglcp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      count_r      <= '0;
      new_phase_r  <= 1'b0;
      old_match_r  <= 1'b0;
      relay_r      <= 1'b0;
      for (int i = 0; i < pglcp_pkg::PIN_LENGTH; i++) begin
        stored_pin_r[i] <= pglcp_pkg::CHAR_1 + pglcp_pkg::BYTE_W'(i[1:0]);
      end
    end else begin
      hold_valid_r <= hold_valid_nxt;
      count_r      <= count_nxt;
      new_phase_r  <= new_phase_nxt;
      old_match_r  <= old_match_nxt;
      relay_r      <= relay_nxt;
      stored_pin_r <= stored_pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) hold_byte_r <= in_ch.rx_byte;
    frame_pin_r   <= frame_pin_nxt;
    pending_pin_r <= pending_pin_nxt;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pglcp_pkg::CNT_W'(pglcp_pkg::PIN_LENGTH))
    else $error("byte count beyond frame length");

  a_phase_count: assert property (@(posedge clk) disable iff (!rst_n)
    new_phase_r |-> (count_r < pglcp_pkg::CNT_W'(pglcp_pkg::PIN_LENGTH)))
    else $error("new-pin run longer than pin length");

  a_phase_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(new_phase_r) |-> $past(fire && frame_last))
    else $error("new-pin run started outside a frame end");
`endif

endmodule

[hdl/pglcp_reply.sv]
// reply serializer holding the current reply and sending it one byte per cycle while out_ch.ready is high
`timescale 1ns / 1ps

module pglcp_reply (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pglcp_pkg::reply_req_t req,
  output logic                  req_ready,
  pglcp_out_if.source           out_ch
);

  logic                                busy_r, busy_nxt;
  pglcp_pkg::reply_kind_t              kind_r, kind_nxt;
  logic [pglcp_pkg::REPLY_IDX_W-1:0]   idx_r, idx_nxt;
  logic                                relay_r, relay_nxt;
  logic                                last;
  logic                                load;

  assign last = (idx_r == pglcp_pkg::reply_last_idx(kind_r));

  assign out_ch.valid        = busy_r;
  assign out_ch.reply_byte   = pglcp_pkg::reply_char(kind_r, idx_r);
  assign out_ch.reply_last   = last;
  assign out_ch.relay_unlock = relay_r;

  // a new reply may load in the cycle the closing newline leaves
  assign req_ready = !busy_r || (out_ch.ready && last);
  assign load      = req_ready && (req.kind != pglcp_pkg::REPLY_NONE);

  always_comb begin
    busy_nxt  = busy_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    relay_nxt = relay_r;
    if (load) begin
      busy_nxt  = 1'b1;
      kind_nxt  = req.kind;
      idx_nxt   = '0;
      relay_nxt = req.relay;
    end else if (busy_r && out_ch.ready) begin
      if (last) busy_nxt = 1'b0;
      else      idx_nxt  = idx_r + pglcp_pkg::REPLY_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    relay_r <= relay_nxt;
  end

`ifndef SYNTHESIS
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_ch.ready && last && !load) |=> !busy_r)
    else $error("serializer still busy after closing newline");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && idx_r == '0))
    else $error("reply did not start at its first byte");

  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == pglcp_pkg::REPLY_OK) |->
      (idx_r <= pglcp_pkg::REPLY_IDX_W'(pglcp_pkg::OK_LEN - 1)))
    else $error("ok reply index past its newline");
`endif

endmodule

[hdl/pin_guarded_lock_command_parser_core.sv]
// Lock command parser top level.
// in_ch carries received bytes, one per item, grouped by count alone into frames
// of four pin bytes and one command byte (U/u unlock, L/l lock, C/c change pin,
// followed by four new pin bytes). out_ch carries reply bytes "OK\n" or "ERR\n",
// one per item, with reply_last on the newline and relay_unlock giving the relay
// level after the command that caused the reply.
// An accepted byte is held in the input register, and its reply is loaded into
// the serializer register that drives out_ch, once the serializer can take it.
// Throughput: one byte per cycle while no reply is due; a reply of 3 or 4 bytes
// leaves out_ch from the single serializer. A reply-producing byte waits in the
// input register until the serializer frees, which can be the cycle its
// previous newline leaves; bytes behind it then stall on in_ch.ready.
// When out_ch.ready is low the current reply byte holds and the serializer
// stops, and once the input register fills in_ch.ready drops.
// Reset (rst_n low, synchronous) empties both stages, clears the byte count,
// clears the parser's relay level to locked and restores pin 1234.
`timescale 1ns / 1ps

module pin_guarded_lock_command_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  pglcp_in_if.sink    in_ch,
  pglcp_out_if.source out_ch
);

  pglcp_pkg::reply_req_t req;
  logic                  req_ready;

  pglcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req       (req),
    .req_ready (req_ready)
  );

  pglcp_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

endmodule
